>>> design/vdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdl_pkg : shared types and constants for the vertex diffuse lighting core
// Payload structs, configuration struct, register indexes and table sizing.
// ----------------------------------------------------------------------------
package vdl_pkg;

    localparam int MAX_LIGHTS = 8;
    localparam int TIDX_W     = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);

    localparam logic [15:0] SHADE_MAX = 16'd65280;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SHADE = 1'b1;

    // light kinds
    localparam logic KIND_POINT    = 1'b0;
    localparam logic KIND_PARALLEL = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_LIGHT_COUNT = 3'd0;
    localparam logic [2:0] REG_PERSP_ON    = 3'd1;
    localparam logic [2:0] REG_X_SCALE     = 3'd2;
    localparam logic [2:0] REG_Y_SCALE     = 3'd3;
    localparam logic [2:0] REG_Z_SCALE     = 3'd4;
    localparam logic [2:0] REG_AMBIENT     = 3'd5;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         light_index;
        logic               light_kind;
        logic [47:0]        light_radius;
        logic [15:0]        light_intensity;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               negate_dot;
    } in_t;

    typedef struct packed {
        logic [15:0] shade;
        logic        clamped;
    } out_t;

    typedef struct packed {
        logic [3:0]  light_count;
        logic        perspective_on;
        logic [23:0] x_scale;
        logic [23:0] y_scale;
        logic [23:0] z_scale;
        logic [7:0]  ambient_level;
    } cfg_t;

    // classified item handed from the front queue to the engine
    typedef struct packed {
        logic is_load;
        logic load_ok;
        in_t  item;
    } qitem_t;

endpackage

>>> design/vdl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdl_front : input acceptance, classification and two-entry queue
// Decodes each incoming transaction as a table load or a shade request.
// ----------------------------------------------------------------------------
module vdl_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vdl_pkg::in_t   s_data,
    output logic           q_valid,
    input  logic           q_ready,
    output vdl_pkg::qitem_t q_item
);
    import vdl_pkg::*;

    qitem_t     fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    qitem_t     cls;

    always_comb begin
        cls.item    = s_data;
        cls.is_load = (s_data.req_type == REQ_LOAD);
        cls.load_ok = (32'(s_data.light_index) < MAX_LIGHTS);
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> design/vdl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdl_div : shared restoring divider, one quotient bit per cycle
// Numerator arrives left-aligned; iters gives its significant width.
// ----------------------------------------------------------------------------
module vdl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [49:0] den,
    input  logic [6:0]  iters,
    output logic        done,
    output logic [63:0] quot
);
    import vdl_pkg::*;

    logic [63:0] num_reg;
    logic [49:0] den_reg;
    logic [49:0] rem_reg;
    logic [63:0] quot_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [50:0] trial;
    logic        qbit;

    assign trial = {rem_reg, num_reg[63]};
    assign qbit  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= 50'd0;
            quot_reg <= 64'd0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[62:0], qbit};
            rem_reg  <= qbit ? 50'(trial - {1'b0, den_reg}) : trial[49:0];
        end
    end

endmodule

>>> design/vdl_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdl_isqrt : integer square root, one result bit per cycle
// Floor square root of a 42-bit squared length.
// ----------------------------------------------------------------------------
module vdl_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [41:0] val,
    output logic        done,
    output logic [20:0] root
);
    import vdl_pkg::*;

    logic [42:0] x_reg, res_reg, bit_reg;
    logic        busy_reg, done_reg;
    logic [42:0] tst;

    assign tst  = res_reg + bit_reg;
    assign done = done_reg;
    assign root = res_reg[20:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == 43'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= 43'(val);
            res_reg <= 43'd0;
            bit_reg <= 43'd1 << 40;
        end else if (busy_reg) begin
            if (x_reg >= tst) begin
                x_reg   <= x_reg - tst;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

>>> design/vdl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdl_back : lighting engine with light table and result register
// Walks the active lights one at a time through a sequenced datapath.
// ----------------------------------------------------------------------------
module vdl_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  vdl_pkg::cfg_t   cfg,
    input  logic            q_valid,
    output logic            q_ready,
    input  vdl_pkg::qitem_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output vdl_pkg::out_t   m_data
);
    import vdl_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_READ  = 5'd1;
    localparam logic [4:0] ST_MAG   = 5'd2;
    localparam logic [4:0] ST_DIR   = 5'd3;
    localparam logic [4:0] ST_QWAIT = 5'd4;
    localparam logic [4:0] ST_SQ    = 5'd5;
    localparam logic [4:0] ST_NORM  = 5'd6;
    localparam logic [4:0] ST_LEN   = 5'd7;
    localparam logic [4:0] ST_NUM   = 5'd8;
    localparam logic [4:0] ST_SQRT  = 5'd9;
    localparam logic [4:0] ST_SQRTW = 5'd10;
    localparam logic [4:0] ST_DDIV  = 5'd11;
    localparam logic [4:0] ST_DDIVW = 5'd12;
    localparam logic [4:0] ST_AM1   = 5'd13;
    localparam logic [4:0] ST_AM2   = 5'd14;
    localparam logic [4:0] ST_ADIVW = 5'd15;
    localparam logic [4:0] ST_PAR   = 5'd16;
    localparam logic [4:0] ST_PDOT  = 5'd17;
    localparam logic [4:0] ST_ACC   = 5'd18;
    localparam logic [4:0] ST_FIN   = 5'd19;

    // light table
    logic               tbl_kind [MAX_LIGHTS];
    logic signed [31:0] tbl_x    [MAX_LIGHTS];
    logic signed [31:0] tbl_y    [MAX_LIGHTS];
    logic signed [31:0] tbl_z    [MAX_LIGHTS];
    logic [47:0]        tbl_rad  [MAX_LIGHTS];
    logic [15:0]        tbl_int  [MAX_LIGHTS];

    logic [4:0]          state_reg;
    logic [CNT_W-1:0]    k_reg, cnt_reg;
    logic [1:0]          ax_reg;
    logic signed [31:0]  vert_reg [3];
    logic signed [15:0]  nrm_reg  [3];
    logic                negd_reg;
    logic signed [31:0]  lv_reg   [3];
    logic [47:0]         lrad_reg;
    logic [15:0]         lint_reg;
    logic [31:0]         mag_reg, q_reg;
    logic                neg_reg  [3];
    logic [55:0]         dir_reg  [3];
    logic [55:0]         big_reg;
    logic [49:0]         dist2_reg;
    logic [41:0]         len2_reg;
    logic signed [49:0]  num_reg;
    logic [20:0]         len_reg;
    logic signed [33:0]  dot_reg;
    logic [39:0]         prod_reg;
    logic [55:0]         acc_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;

    logic [TIDX_W-1:0]   kidx, widx;
    logic [23:0]         sc_raw, sc;
    logic signed [32:0]  dsub;
    logic [63:0]         qq;
    logic [19:0]         e;
    logic signed [20:0]  se;
    logic signed [36:0]  np;
    logic signed [47:0]  pp;
    logic [49:0]         abs_num;
    logic [63:0]         aprod;
    logic signed [33:0]  sd;
    logic [48:0]         contrib;
    logic [42:0]         sum;
    logic [CNT_W-1:0]    cnt_clamp;

    logic        div_start, div_done;
    logic [63:0] div_num, div_quot;
    logic [49:0] div_den;
    logic [6:0]  div_iters;
    logic        sq_start, sq_done;
    logic [20:0] sq_root;

    assign kidx    = k_reg[TIDX_W-1:0];
    assign widx    = TIDX_W'(q_item.item.light_index);
    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cnt_clamp = (32'(cfg.light_count) > MAX_LIGHTS) ? CNT_W'(MAX_LIGHTS)
                                                          : CNT_W'(cfg.light_count);

    always_comb begin
        case (ax_reg)
            2'd0:    sc_raw = cfg.x_scale;
            2'd1:    sc_raw = cfg.y_scale;
            default: sc_raw = cfg.z_scale;
        endcase
        sc = (sc_raw == 24'd0) ? 24'd1 : sc_raw;
    end

    always_comb begin
        dsub    = 33'(vert_reg[ax_reg]) - 33'(lv_reg[ax_reg]);
        qq      = 64'(q_reg) * 64'(q_reg);
        e       = dir_reg[ax_reg][19:0];
        se      = neg_reg[ax_reg] ? -signed'({1'b0, e}) : signed'({1'b0, e});
        np      = nrm_reg[ax_reg] * se;
        pp      = nrm_reg[ax_reg] * lv_reg[ax_reg];
        abs_num = (num_reg < 0) ? 50'(-num_reg) : 50'(num_reg);
        aprod   = 64'(prod_reg) + ((64'(lint_reg) * 64'(lrad_reg[47:24])) << 24);
        sd      = negd_reg ? -dot_reg : dot_reg;
        contrib = 49'(sd[32:0]) * 49'(lint_reg);
        sum     = 43'(acc_reg[55:14]) + 43'({cfg.ambient_level, 8'h00});
    end

    // launches for the shared divider and the square root unit
    always_comb begin
        div_start = 1'b0;
        div_num   = 64'd0;
        div_den   = 50'd0;
        div_iters = 7'd64;
        sq_start  = (state_reg == ST_SQRT);
        unique case (state_reg)
            ST_DIR: begin
                div_start = cfg.perspective_on;
                div_num   = {mag_reg, 32'd0};
                div_den   = 50'(sc);
                div_iters = 7'd48;
            end
            ST_DDIV: begin
                div_start = 1'b1;
                div_num   = {abs_num[39:0], 24'd0};
                div_den   = 50'(len_reg);
                div_iters = 7'd40;
            end
            ST_AM2: begin
                div_start = 1'b1;
                div_num   = aprod;
                div_den   = dist2_reg;
                div_iters = 7'd64;
            end
            default: ;
        endcase
    end

    vdl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .iters   (div_iters),
        .done    (div_done),
        .quot    (div_quot)
    );

    vdl_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .val     (len2_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid && q_item.is_load && q_item.load_ok) begin
            tbl_kind[widx] <= q_item.item.light_kind;
            tbl_x[widx]    <= q_item.item.a_x;
            tbl_y[widx]    <= q_item.item.a_y;
            tbl_z[widx]    <= q_item.item.a_z;
            tbl_rad[widx]  <= q_item.item.light_radius;
            tbl_int[widx]  <= q_item.item.light_intensity;
        end
        if (state_reg == ST_READ) begin
            lv_reg[0] <= tbl_x[kidx];
            lv_reg[1] <= tbl_y[kidx];
            lv_reg[2] <= tbl_z[kidx];
            lrad_reg  <= tbl_rad[kidx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            cnt_reg     <= '0;
            ax_reg      <= 2'd0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && !q_item.is_load) begin
                        vert_reg[0] <= q_item.item.a_x;
                        vert_reg[1] <= q_item.item.a_y;
                        vert_reg[2] <= q_item.item.a_z;
                        nrm_reg[0]  <= q_item.item.normal_x;
                        nrm_reg[1]  <= q_item.item.normal_y;
                        nrm_reg[2]  <= q_item.item.normal_z;
                        negd_reg    <= q_item.item.negate_dot;
                        cnt_reg     <= cnt_clamp;
                        k_reg       <= '0;
                        acc_reg     <= 56'd0;
                        state_reg   <= (cnt_clamp == '0) ? ST_FIN : ST_READ;
                    end
                end
                ST_READ: begin
                    lint_reg  <= tbl_int[kidx];
                    ax_reg    <= 2'd0;
                    num_reg   <= 50'sd0;
                    dist2_reg <= 50'd0;
                    big_reg   <= 56'd0;
                    len2_reg  <= 42'd0;
                    state_reg <= (tbl_kind[kidx] == KIND_PARALLEL) ? ST_PAR : ST_MAG;
                end
                ST_PAR: begin
                    num_reg <= num_reg + 50'(pp);
                    if (ax_reg == 2'd2) begin
                        state_reg <= ST_PDOT;
                    end else begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                ST_PDOT: begin
                    // divide by 65536, truncating toward zero
                    dot_reg   <= (num_reg < 0) ? -34'(abs_num >> 16) : 34'(abs_num >> 16);
                    state_reg <= ST_ACC;
                end
                ST_MAG: begin
                    neg_reg[ax_reg] <= dsub[32];
                    mag_reg   <= dsub[32] ? 32'(-dsub) : dsub[31:0];
                    state_reg <= ST_DIR;
                end
                ST_DIR: begin
                    if (cfg.perspective_on) begin
                        dir_reg[ax_reg] <= 56'(mag_reg) * 56'(sc);
                        state_reg       <= ST_QWAIT;
                    end else begin
                        dir_reg[ax_reg] <= 56'(mag_reg);
                        q_reg           <= mag_reg;
                        state_reg       <= ST_SQ;
                    end
                end
                ST_QWAIT: begin
                    if (div_done) begin
                        q_reg     <= (div_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                               : div_quot[31:0];
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    dist2_reg <= dist2_reg + 50'(qq >> 16);
                    if (dir_reg[ax_reg] > big_reg) begin
                        big_reg <= dir_reg[ax_reg];
                    end
                    if (ax_reg == 2'd2) begin
                        ax_reg    <= 2'd0;
                        state_reg <= ST_NORM;
                    end else begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_MAG;
                    end
                end
                ST_NORM: begin
                    // coarse then fine steps until the largest sits in [2^19, 2^20)
                    if (big_reg == 56'd0) begin
                        dot_reg   <= 34'sd0;
                        state_reg <= ST_ACC;
                    end else if (big_reg >= (56'd1 << 28)) begin
                        for (int i = 0; i < 3; i++) dir_reg[i] <= dir_reg[i] >> 8;
                        big_reg <= big_reg >> 8;
                    end else if (big_reg >= (56'd1 << 20)) begin
                        for (int i = 0; i < 3; i++) dir_reg[i] <= dir_reg[i] >> 1;
                        big_reg <= big_reg >> 1;
                    end else if (big_reg < (56'd1 << 11)) begin
                        for (int i = 0; i < 3; i++) dir_reg[i] <= dir_reg[i] << 8;
                        big_reg <= big_reg << 8;
                    end else if (big_reg < (56'd1 << 19)) begin
                        for (int i = 0; i < 3; i++) dir_reg[i] <= dir_reg[i] << 1;
                        big_reg <= big_reg << 1;
                    end else begin
                        ax_reg    <= 2'd0;
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    len2_reg <= len2_reg + 42'(40'(e) * 40'(e));
                    if (ax_reg == 2'd2) begin
                        ax_reg    <= 2'd0;
                        state_reg <= ST_NUM;
                    end else begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                ST_NUM: begin
                    num_reg <= num_reg + 50'(np);
                    if (ax_reg == 2'd2) begin
                        state_reg <= ST_SQRT;
                    end else begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                ST_SQRT: begin
                    state_reg <= ST_SQRTW;
                end
                ST_SQRTW: begin
                    if (sq_done) begin
                        len_reg <= sq_root;
                        if (sq_root == 21'd0) begin
                            dot_reg   <= 34'sd0;
                            state_reg <= ST_ACC;
                        end else begin
                            state_reg <= ST_DDIV;
                        end
                    end
                end
                ST_DDIV: begin
                    state_reg <= ST_DDIVW;
                end
                ST_DDIVW: begin
                    if (div_done) begin
                        dot_reg   <= (num_reg < 0) ? -34'(div_quot[32:0]) : 34'(div_quot[32:0]);
                        state_reg <= (dist2_reg > 50'(lrad_reg)) ? ST_AM1 : ST_ACC;
                    end
                end
                ST_AM1: begin
                    prod_reg  <= 40'(lint_reg) * 40'(lrad_reg[23:0]);
                    state_reg <= ST_AM2;
                end
                ST_AM2: begin
                    state_reg <= ST_ADIVW;
                end
                ST_ADIVW: begin
                    if (div_done) begin
                        lint_reg  <= div_quot[15:0];
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (sd > 0) begin
                        acc_reg <= acc_reg + 56'(contrib);
                    end
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg + 1'b1 == cnt_reg) ? ST_FIN : ST_READ;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        if (sum > 43'(SHADE_MAX)) begin
                            m_data_reg.shade   <= SHADE_MAX;
                            m_data_reg.clamped <= 1'b1;
                        end else begin
                            m_data_reg.shade   <= sum[15:0];
                            m_data_reg.clamped <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> design/vertex_diffuse_lighting_core.sv
`timescale 1ns / 1ps
// Sequencing: a shade item walks each active light in turn; a point light also waits on
// the 21-bit square root and the bit-serial divider (48-, 40- and 64-bit quotients);
// loads are written to the table as the engine takes them from the queue.
// Throughput: one item in the engine at a time; a two-entry queue takes input while it has room.
// Reset: synchronous active-low aresetn resets control and configuration; the light
// table holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// vertex_diffuse_lighting_core : per-vertex Lambert diffuse shading
// Configuration registers, front queue and lighting engine.
// ----------------------------------------------------------------------------
module vertex_diffuse_lighting_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vdl_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vdl_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    import vdl_pkg::*;

    cfg_t   cfg_reg;
    logic   q_valid, q_ready;
    qitem_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.light_count    <= 4'd0;
            cfg_reg.perspective_on <= 1'b0;
            cfg_reg.x_scale        <= 24'd65536;
            cfg_reg.y_scale        <= 24'd65536;
            cfg_reg.z_scale        <= 24'd65536;
            cfg_reg.ambient_level  <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LIGHT_COUNT: cfg_reg.light_count    <= cfg_data[3:0];
                REG_PERSP_ON:    cfg_reg.perspective_on <= cfg_data[0];
                REG_X_SCALE:     cfg_reg.x_scale        <= cfg_data;
                REG_Y_SCALE:     cfg_reg.y_scale        <= cfg_data;
                REG_Z_SCALE:     cfg_reg.z_scale        <= cfg_data;
                REG_AMBIENT:     cfg_reg.ambient_level  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    vdl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    vdl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a clamped result always carries the ceiling value
    a_clamp_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clamped |-> m_data.shade == SHADE_MAX)
        else $error("clamped result without ceiling shade");

    // shade never exceeds the ceiling
    a_shade_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.shade <= SHADE_MAX)
        else $error("shade above ceiling");

    // a queued transaction taken by the engine leaves the front stage free for input
    a_queue_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready && !s_valid |=> s_ready)
        else $error("queue did not free a slot after a pop");

endmodule
